@@ rtl/pcxd_pkg.sv @@
package pcxd_pkg;

    localparam int BYTE_W       = 8;
    localparam int COL_OUT_W    = 13;
    localparam int PLANE_W      = 2;
    localparam int ROW_W        = 12;
    localparam int CNT_W        = 6;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int PLANE_CNT_W  = 3;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int LINE_WIDTH_MAX = (1 << CFG_DATA_W) - 1;
    localparam int ROWS_MAX       = 1 << ROW_W;
    localparam int PLANES_MAX     = 1 << PLANE_W;

    localparam logic [BYTE_W-1:0] RUN_MARK = 8'hC0;
    localparam int PLANE_BITS = 7;
    localparam int STRIDE_MAX = PLANE_BITS + 1;

    localparam logic [CFG_DATA_W-1:0]  LINE_WIDTH_RST  = 13'd320;
    localparam logic [CFG_DATA_W-1:0]  LINE_COUNT_RST  = 13'd200;
    localparam logic                   PLANAR_MODE_RST = 1'b0;
    localparam logic [PLANE_CNT_W-1:0] PLANE_COUNT_RST = 3'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_WIDTH  = 2'd0,
        CFG_LINE_COUNT  = 2'd1,
        CFG_PLANAR_MODE = 2'd2,
        CFG_PLANE_COUNT = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_BYTE,
        ST_VALUE,
        ST_RUN
    } ctrl_state_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0]  line_width;
        logic [CFG_DATA_W-1:0]  line_count;
        logic                   planar_mode;
        logic [PLANE_CNT_W-1:0] plane_count;
    } cfg_t;

    typedef struct packed {
        logic load_count;
        logic load_run;
        logic step;
        logic emit;
        logic from_input;
        logic last;
    } cmd_t;

    typedef struct packed {
        logic finished;
        logic marker;
        logic count_zero;
        logic count_one;
        logic col_at_end;
        logic next_at_end;
        logic slot_free;
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0]    pixel_value;
        logic [COL_OUT_W-1:0] column;
        logic [PLANE_W-1:0]   plane;
        logic [ROW_W-1:0]     row;
        logic                 run_last;
        logic                 image_done;
    } item_t;

endpackage

@@ rtl/pcxd_byte_if.sv @@
interface pcxd_byte_if;
    logic                        valid;
    logic                        ready;
    logic [pcxd_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

@@ rtl/pcxd_pix_if.sv @@
interface pcxd_pix_if;
    logic                           valid;
    logic                           ready;
    logic [pcxd_pkg::BYTE_W-1:0]    pixel_value;
    logic [pcxd_pkg::COL_OUT_W-1:0] column;
    logic [pcxd_pkg::PLANE_W-1:0]   plane;
    logic [pcxd_pkg::ROW_W-1:0]     row;
    logic                           run_last;
    logic                           image_done;

    modport source (output valid, output pixel_value, output column, output plane,
                    output row, output run_last, output image_done, input ready);
    modport sink   (input valid, input pixel_value, input column, input plane,
                    input row, input run_last, input image_done, output ready);
endinterface

@@ rtl/pcxd_cfg_if.sv @@
interface pcxd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [pcxd_pkg::CFG_IDX_W-1:0]  index;
    logic [pcxd_pkg::CFG_DATA_W-1:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

@@ rtl/pcxd_cfg_regs.sv @@
module pcxd_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [pcxd_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [pcxd_pkg::CFG_DATA_W-1:0] wr_data,
    output pcxd_pkg::cfg_t                  cfg
);

    pcxd_pkg::cfg_t cfg_reg;
    pcxd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (pcxd_pkg::cfg_index_t'(wr_index))
                pcxd_pkg::CFG_LINE_WIDTH:  cfg_next.line_width  = wr_data;
                pcxd_pkg::CFG_LINE_COUNT:  cfg_next.line_count  = wr_data;
                pcxd_pkg::CFG_PLANAR_MODE: cfg_next.planar_mode = wr_data[0];
                pcxd_pkg::CFG_PLANE_COUNT:
                    cfg_next.plane_count = wr_data[pcxd_pkg::PLANE_CNT_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_width  <= pcxd_pkg::LINE_WIDTH_RST;
            cfg_reg.line_count  <= pcxd_pkg::LINE_COUNT_RST;
            cfg_reg.planar_mode <= pcxd_pkg::PLANAR_MODE_RST;
            cfg_reg.plane_count <= pcxd_pkg::PLANE_COUNT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/pcxd_ctrl.sv @@
module pcxd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pcxd_pkg::status_t status,
    output pcxd_pkg::cmd_t    cmd
);

    pcxd_pkg::ctrl_state_t state_reg;
    pcxd_pkg::ctrl_state_t state_next;

    logic accept;
    logic run_empty;
    logic run_last;

    assign accept    = in_valid && in_ready;
    assign run_empty = status.count_zero || status.col_at_end;
    assign run_last  = status.count_one || status.next_at_end;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pcxd_pkg::ST_BYTE:
            begin
                if (accept && !status.finished && status.marker)
                    state_next = pcxd_pkg::ST_VALUE;
            end
            pcxd_pkg::ST_VALUE:
            begin
                if (accept)
                    state_next = pcxd_pkg::ST_RUN;
            end
            pcxd_pkg::ST_RUN:
            begin
                if (run_empty || (status.slot_free && run_last))
                    state_next = pcxd_pkg::ST_BYTE;
            end
            default: state_next = pcxd_pkg::ST_BYTE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            pcxd_pkg::ST_BYTE:
            begin
                in_ready = status.finished || status.slot_free;
                if (accept && !status.finished)
                begin
                    if (status.marker)
                    begin
                        cmd.load_count = 1'b1;
                    end
                    else
                    begin
                        cmd.step       = 1'b1;
                        cmd.emit       = 1'b1;
                        cmd.from_input = 1'b1;
                        cmd.last       = 1'b1;
                    end
                end
            end
            pcxd_pkg::ST_VALUE:
            begin
                in_ready     = 1'b1;
                cmd.load_run = accept;
            end
            pcxd_pkg::ST_RUN:
            begin
                if (run_empty)
                begin
                    cmd.step = 1'b1;
                end
                else if (status.slot_free)
                begin
                    cmd.step = 1'b1;
                    cmd.emit = 1'b1;
                    cmd.last = run_last;
                end
            end
            default:
            begin
                in_ready = 1'b0;
                cmd      = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pcxd_pkg::ST_BYTE;
        else
            state_reg <= state_next;
    end

endmodule

@@ rtl/pcxd_datapath.sv @@
module pcxd_datapath #(
    parameter int MAX_WIDTH = pcxd_pkg::MAX_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pcxd_pkg::cfg_t              cfg,
    input  pcxd_pkg::cmd_t              cmd,
    output pcxd_pkg::status_t           status,
    input  logic [pcxd_pkg::BYTE_W-1:0] data_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output pcxd_pkg::item_t             out_item
);

    localparam int WIDTH_CAP = (MAX_WIDTH < pcxd_pkg::LINE_WIDTH_MAX) ?
                               MAX_WIDTH : pcxd_pkg::LINE_WIDTH_MAX;
    localparam int COL_W     = $clog2(WIDTH_CAP + pcxd_pkg::STRIDE_MAX);
    localparam int RCNT_W    = pcxd_pkg::ROW_W + 1;

    logic [COL_W-1:0]                col_reg, col_next;
    logic [pcxd_pkg::PLANE_W-1:0]    plane_reg, plane_next;
    logic [pcxd_pkg::ROW_W-1:0]      row_reg, row_next;
    logic                            fin_reg, fin_next;
    logic [pcxd_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [pcxd_pkg::BYTE_W-1:0]     run_val_reg, run_val_next;
    logic                            out_valid_reg, out_valid_next;
    pcxd_pkg::item_t                 item_reg, item_next;

    logic [COL_W-1:0]                width_eff;
    logic [RCNT_W-1:0]               rows_eff;
    logic [pcxd_pkg::PLANE_CNT_W-1:0] planes_eff;
    logic [COL_W-1:0]                stride;
    logic [COL_W-1:0]                col_plus;
    logic [COL_W-1:0]                step_col;
    logic                            line_end;
    logic                            plane_last;
    logic                            row_last;
    logic                            done_now;

    // clamp the registers to their legal ranges
    always_comb
    begin
        if (cfg.line_width == '0)
            width_eff = COL_W'(1);
        else if (cfg.line_width > WIDTH_CAP)
            width_eff = COL_W'(WIDTH_CAP);
        else
            width_eff = COL_W'(cfg.line_width);

        if (cfg.line_count == '0)
            rows_eff = RCNT_W'(1);
        else if (cfg.line_count > pcxd_pkg::ROWS_MAX)
            rows_eff = RCNT_W'(pcxd_pkg::ROWS_MAX);
        else
            rows_eff = RCNT_W'(cfg.line_count);

        if (cfg.plane_count == '0)
            planes_eff = pcxd_pkg::PLANE_CNT_W'(1);
        else if (cfg.plane_count > pcxd_pkg::PLANES_MAX)
            planes_eff = pcxd_pkg::PLANE_CNT_W'(pcxd_pkg::PLANES_MAX);
        else
            planes_eff = cfg.plane_count;
    end

    assign stride     = cfg.planar_mode ? COL_W'(pcxd_pkg::STRIDE_MAX) : COL_W'(1);
    assign col_plus   = col_reg + stride;
    assign step_col   = cmd.emit ? col_plus : col_reg;
    assign line_end   = step_col >= width_eff;
    assign plane_last = (pcxd_pkg::PLANE_CNT_W'(plane_reg) + pcxd_pkg::PLANE_CNT_W'(1))
                        >= planes_eff;
    assign row_last   = (RCNT_W'(row_reg) + RCNT_W'(1)) >= rows_eff;
    assign done_now   = line_end && plane_last && row_last;

    always_comb
    begin
        col_next       = col_reg;
        plane_next     = plane_reg;
        row_next       = row_reg;
        fin_next       = fin_reg;
        count_next     = count_reg;
        run_val_next   = run_val_reg;
        out_valid_next = out_valid_reg && !out_ready;
        item_next      = item_reg;

        if (cmd.load_count)
            count_next = data_byte[pcxd_pkg::CNT_W-1:0];
        if (cmd.load_run)
            run_val_next = data_byte;

        if (cmd.step)
        begin
            if (!cmd.from_input)
            begin
                if (cmd.emit && !cmd.last)
                    count_next = count_reg - pcxd_pkg::CNT_W'(1);
                else
                    count_next = '0;
            end

            if (line_end)
            begin
                col_next = '0;
                if (plane_last)
                begin
                    plane_next = '0;
                    if (row_last)
                        fin_next = 1'b1;
                    else
                        row_next = row_reg + pcxd_pkg::ROW_W'(1);
                end
                else
                begin
                    plane_next = plane_reg + pcxd_pkg::PLANE_W'(1);
                end
            end
            else
            begin
                col_next = step_col;
            end
        end

        if (cmd.emit)
        begin
            out_valid_next       = 1'b1;
            item_next.pixel_value = cmd.from_input ? data_byte : run_val_reg;
            item_next.column     = pcxd_pkg::COL_OUT_W'(col_reg);
            item_next.plane      = plane_reg;
            item_next.row        = row_reg;
            item_next.run_last   = cmd.last;
            item_next.image_done = cmd.last && done_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            plane_reg     <= '0;
            row_reg       <= '0;
            fin_reg       <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            plane_reg     <= plane_next;
            row_reg       <= row_next;
            fin_reg       <= fin_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_val_reg <= run_val_next;
        item_reg    <= item_next;
    end

    assign status.finished    = fin_reg;
    assign status.marker      = (data_byte & pcxd_pkg::RUN_MARK) == pcxd_pkg::RUN_MARK;
    assign status.count_zero  = count_reg == '0;
    assign status.count_one   = count_reg == pcxd_pkg::CNT_W'(1);
    assign status.col_at_end  = col_reg >= width_eff;
    assign status.next_at_end = col_plus >= width_eff;
    assign status.slot_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_item  = item_reg;

`ifndef SYNTHESIS
    // no beat may be produced once the image is complete
    a_no_emit_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg |-> !cmd.emit)
        else $error("item emitted after the last row");

    // a new beat never overwrites one that is still waiting
    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten");

    // the closing beat of the image raises the finished flag
    a_done_sets_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.last && done_now) |=> fin_reg)
        else $error("image done without finished flag");

    // image done only ever rides on the last beat of a byte
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && item_reg.image_done) |-> item_reg.run_last)
        else $error("image done on a beat that is not the last");

    // the column never runs more than one stride past the widest line
    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= COL_W'(WIDTH_CAP + pcxd_pkg::STRIDE_MAX - 1))
        else $error("column out of range");
`endif

endmodule

@@ rtl/pcx_rle_line_decoder.sv @@
// run-length decoder for the body of a pcx image. compressed bytes arrive one beat at a
// time on data; decoded items leave on pixels, each carrying the pixel byte (or eight
// plane bits, msb leftmost, in planar mode) with its column, plane and row. a literal
// byte gives one item; a run marker is taken, then its value byte, and the run then
// gives one item per cycle while the output register is free (an empty run gives none).
// the pace is set by the controller walking a run through a single output register,
// one column step per cycle while it is free. registers are written on cfg and
// are taken at once; write them between images. once the last row is complete every
// further byte is swallowed until reset. no clearing pass is needed after reset.
module pcx_rle_line_decoder #(
    parameter int MAX_WIDTH = pcxd_pkg::MAX_WIDTH_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    pcxd_byte_if.sink   data,
    pcxd_pix_if.source  pixels,
    pcxd_cfg_if.sink    cfg
);

    pcxd_pkg::cfg_t    cfg_q;
    pcxd_pkg::cmd_t    cmd;
    pcxd_pkg::status_t status;
    pcxd_pkg::item_t   item;

    // register file, always ready for a write beat
    assign cfg.ready = 1'b1;

    pcxd_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid && cfg.ready),
        .wr_index (cfg.index),
        .wr_data  (cfg.wdata),
        .cfg      (cfg_q)
    );

    // controller: literal / marker / value / run sequencing
    pcxd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (data.valid),
        .in_ready (data.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: position counters, run count, output register
    pcxd_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_q),
        .cmd       (cmd),
        .status    (status),
        .data_byte (data.data_byte),
        .out_valid (pixels.valid),
        .out_ready (pixels.ready),
        .out_item  (item)
    );

    // unpack the output beat
    assign pixels.pixel_value = item.pixel_value;
    assign pixels.column      = item.column;
    assign pixels.plane       = item.plane;
    assign pixels.row         = item.row;
    assign pixels.run_last    = item.run_last;
    assign pixels.image_done  = item.image_done;

endmodule

@@ tb/tb_pcx_rle_line_decoder.sv @@
module tb_pcx_rle_line_decoder;

    timeunit 1ns;
    timeprecision 1ps;

    import pcxd_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 3;
    localparam int MAX_W         = MAX_WIDTH_DEF;
    // an empty run leaves nothing behind, so a short pause after the last item is enough
    // for the decoder to go quiet
    localparam int SETTLE_CYCLES = 10;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_BYTES   = 50;

    logic clk = 1'b0;
    logic rst_n;

    pcxd_byte_if byte_bus ();
    pcxd_pix_if  pix_bus ();
    pcxd_cfg_if  reg_bus ();

    pcx_rle_line_decoder #(
        .MAX_WIDTH (MAX_W)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .data   (byte_bus),
        .pixels (pix_bus),
        .cfg    (reg_bus)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // compressed bytes waiting for the driver, and decoded items still owed by the block
    logic [BYTE_W-1:0] bytes_pending[$];
    item_t             pixels_due[$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int mismatches     = 0;
    int cycle_count    = 0;

    // shadow copy of the register file, as the block should hold it
    logic [CFG_DATA_W-1:0]  cfg_width  = LINE_WIDTH_RST;
    logic [CFG_DATA_W-1:0]  cfg_rows   = LINE_COUNT_RST;
    logic                   cfg_planar = PLANAR_MODE_RST;
    logic [PLANE_CNT_W-1:0] cfg_planes = PLANE_COUNT_RST;

    // decoder position, tracked alongside the block
    logic                 await_val    = 1'b0;
    logic [CNT_W-1:0]     pend_cnt     = '0;
    logic [COL_OUT_W-1:0] col_pos      = '0;
    logic [PLANE_W-1:0]   plane_idx    = '0;
    logic [ROW_W-1:0]     row_idx      = '0;
    logic                 img_finished = 1'b0;

    task automatic flag_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // works out the items one accepted byte gives and queues them as due
    task automatic expand_byte(input logic [BYTE_W-1:0] b);
        int    eff_width;
        int    eff_rows;
        int    eff_planes;
        int    stride;
        int    left;
        logic  last_line;
        item_t it;
        item_t run_items[$];

        // out of range register values are pulled back into range on use
        eff_width  = (cfg_width == 0) ? 1 : (cfg_width > MAX_W) ? MAX_W : int'(cfg_width);
        eff_rows   = (cfg_rows == 0) ? 1 : (cfg_rows > ROWS_MAX) ? ROWS_MAX : int'(cfg_rows);
        eff_planes = (cfg_planes == 0) ? 1
                   : (cfg_planes > PLANES_MAX) ? PLANES_MAX : int'(cfg_planes);
        stride     = cfg_planar ? STRIDE_MAX : 1;
        last_line  = 1'b0;

        // image complete: everything is swallowed
        if (img_finished)
            return;

        it             = '0;
        it.pixel_value = b;
        it.plane       = plane_idx;
        it.row         = row_idx;

        if (await_val)
        begin
            // value byte of a run, repeats stop at the end of the line
            left      = int'(pend_cnt);
            await_val = 1'b0;
            pend_cnt  = '0;
            while (left > 0 && col_pos < eff_width)
            begin
                it.column = col_pos;
                run_items.push_back(it);
                col_pos = col_pos + COL_OUT_W'(stride);
                left--;
            end
        end
        else if ((b & RUN_MARK) == RUN_MARK)
        begin
            // run marker: only the count is kept
            await_val = 1'b1;
            pend_cnt  = b[CNT_W-1:0];
            return;
        end
        else
        begin
            // literal, emitted even when a register change left the column past the width
            it.column = col_pos;
            run_items.push_back(it);
            col_pos = col_pos + COL_OUT_W'(stride);
        end

        // line wrap: plane first, then row, then end of image
        if (col_pos >= eff_width)
        begin
            col_pos = '0;
            if (plane_idx + 1 >= eff_planes)
            begin
                plane_idx = '0;
                if (row_idx + 1 >= eff_rows)
                begin
                    img_finished = 1'b1;
                    last_line    = 1'b1;
                end
                else
                    row_idx = row_idx + ROW_W'(1);
            end
            else
                plane_idx = plane_idx + PLANE_W'(1);
        end

        if (run_items.size() != 0)
        begin
            it            = run_items.pop_back();
            it.run_last   = 1'b1;
            it.image_done = last_line;
            run_items.push_back(it);
            foreach (run_items[i])
                pixels_due.push_back(run_items[i]);
        end
    endtask

    // one register write; the shadow copy takes the value on the accepting edge
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        reg_bus.valid <= 1'b1;
        reg_bus.index <= idx;
        reg_bus.wdata <= value;
        do
            @(posedge clk);
        while (!reg_bus.ready);
        case (idx)
            CFG_LINE_WIDTH:  cfg_width  = value;
            CFG_LINE_COUNT:  cfg_rows   = value;
            CFG_PLANAR_MODE: cfg_planar = value[0];
            CFG_PLANE_COUNT: cfg_planes = value[PLANE_CNT_W-1:0];
            default: ;
        endcase
        reg_bus.valid <= 1'b0;
    endtask

    // checked on the falling edge so the state seen is settled
    task automatic wait_drained();
        do
            @(negedge clk);
        while (bytes_pending.size() != 0 || byte_bus.valid || pixels_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1:       begin src_idle_pct = 65; sink_stall_pct = 0;  end
            2:       begin src_idle_pct = 0;  sink_stall_pct = 65; end
            default: begin src_idle_pct = 32; sink_stall_pct = 32; end
        endcase
    endtask

    // mostly literals and well formed runs, with some loose bytes mixed in
    task automatic queue_random_stream(input int n_bytes);
        int         pushed;
        int         pick;
        logic [5:0] count;
        pushed = 0;
        while (pushed < n_bytes)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                bytes_pending.push_back(8'($urandom_range(8'hBF)));
                pushed++;
            end
            else if (pick < 88)
            begin
                pick  = $urandom_range(9);
                count = (pick == 0) ? 6'd0 : (pick == 1) ? 6'd63 : (pick == 2) ? 6'd1
                      : 6'($urandom_range(63));
                bytes_pending.push_back(RUN_MARK | {2'b00, count});
                bytes_pending.push_back(8'($urandom));
                pushed += 2;
            end
            else
            begin
                bytes_pending.push_back(8'($urandom));
                pushed++;
            end
        end
    endtask

    // byte driver: a new beat goes out only once the previous one has been taken
    always @(posedge clk)
    begin
        if (!rst_n)
            byte_bus.valid <= 1'b0;
        else
        begin
            if (byte_bus.valid && byte_bus.ready)
                expand_byte(byte_bus.data_byte);
            if (!byte_bus.valid || byte_bus.ready)
            begin
                if (bytes_pending.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    byte_bus.valid     <= 1'b1;
                    byte_bus.data_byte <= bytes_pending.pop_front();
                end
                else
                    byte_bus.valid <= 1'b0;
            end
        end
    end

    // item monitor: random back-pressure, every accepted beat checked against the oldest due
    always @(posedge clk)
    begin : pixel_monitor
        item_t want;
        if (!rst_n)
            pix_bus.ready <= 1'b0;
        else
        begin
            if (pix_bus.valid && pix_bus.ready)
            begin
                if (pixels_due.size() == 0)
                    flag_mismatch($sformatf("item with nothing due, value %02h column %0d",
                                            pix_bus.pixel_value, pix_bus.column));
                else
                begin
                    want = pixels_due.pop_front();
                    if (pix_bus.pixel_value !== want.pixel_value)
                        flag_mismatch($sformatf("pixel_value %02h, due %02h",
                                                pix_bus.pixel_value, want.pixel_value));
                    if (pix_bus.column !== want.column)
                        flag_mismatch($sformatf("column %0d, due %0d",
                                                pix_bus.column, want.column));
                    if (pix_bus.plane !== want.plane)
                        flag_mismatch($sformatf("plane %0d, due %0d",
                                                pix_bus.plane, want.plane));
                    if (pix_bus.row !== want.row)
                        flag_mismatch($sformatf("row %0d, due %0d", pix_bus.row, want.row));
                    if (pix_bus.run_last !== want.run_last)
                        flag_mismatch($sformatf("run_last %b, due %b",
                                                pix_bus.run_last, want.run_last));
                    if (pix_bus.image_done !== want.image_done)
                        flag_mismatch($sformatf("image_done %b, due %b",
                                                pix_bus.image_done, want.image_done));
                end
            end
            pix_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // watchdog, also catches items that never arrive
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int                    pick;
        logic [CFG_DATA_W-1:0] value;

        // every input known from time zero
        rst_n              = 1'b0;
        byte_bus.valid     = 1'b0;
        byte_bus.data_byte = '0;
        pix_bus.ready      = 1'b0;
        reg_bus.valid      = 1'b0;
        reg_bus.index      = CFG_LINE_WIDTH;
        reg_bus.wdata      = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: literal extremes, empty run, full 63 run,
        // run values that look like markers themselves
        set_idling(0);
        bytes_pending = {8'h00, 8'hBF, 8'h40, 8'h80, 8'hC0, 8'h55, 8'hFF, 8'hAA,
                         8'hC1, 8'hFF, 8'hC2, 8'hC5};
        wait_drained();

        // narrow line with three planes: column already past the width ends the
        // line on the next literal, then a long run cut short at the line end
        set_idling(2);
        write_reg(CFG_LINE_WIDTH, 13'd13);
        write_reg(CFG_PLANE_COUNT, 13'd3);
        write_reg(CFG_LINE_COUNT, 13'h1FFF);
        bytes_pending = {8'h21, 8'hFF, 8'h11, 8'hC4, 8'h7E};
        wait_drained();

        // width of zero taken as one, planar with upper data bits set, plane count
        // above the limit; a run cut to one item and an empty run at column zero
        set_idling(3);
        write_reg(CFG_LINE_WIDTH, 13'd0);
        write_reg(CFG_PLANAR_MODE, 13'h1FFF);
        write_reg(CFG_PLANE_COUNT, 13'd7);
        bytes_pending = {8'h01, 8'hC3, 8'h99, 8'hC0, 8'h00};
        wait_drained();

        // random phases, each with its own registers and idling; the row count, when rewritten,
        // is set well ahead of the current row so the image does not end early
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            set_idling(phase % 4);
            pick = $urandom_range(99);
            if (pick < 40)
                value = 13'($urandom_range(24, 1));
            else if (pick < 60)
                value = 13'($urandom_range(400, 25));
            else if (pick < 70)
                value = 13'd0;
            else if (pick < 80)
                value = 13'd4096;
            else if (pick < 85)
                value = 13'h1FFF;
            else if (pick < 90)
                value = 13'($urandom_range(8191, 4097));
            else
                value = 13'($urandom_range(4096, 1));
            write_reg(CFG_LINE_WIDTH, value);
            if ($urandom_range(1))
                write_reg(CFG_PLANAR_MODE, 13'($urandom));
            if ($urandom_range(1))
                write_reg(CFG_PLANE_COUNT, 13'($urandom_range(7)));
            if ($urandom_range(1))
                write_reg(CFG_LINE_COUNT, 13'($urandom_range(8191, int'(row_idx) + 100)));
            queue_random_stream(PHASE_BYTES);
            wait_drained();
        end

        // row count of zero: the image ends at the next line end and the
        // rest of the stream is swallowed
        set_idling(1);
        write_reg(CFG_LINE_COUNT, 13'd0);
        write_reg(CFG_LINE_WIDTH, 13'd3);
        write_reg(CFG_PLANE_COUNT, 13'd1);
        write_reg(CFG_PLANAR_MODE, 13'd0);
        bytes_pending = {8'h3C, 8'h3C, 8'h3C};
        queue_random_stream(20);
        wait_drained();

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
